/* design/omp_pkg.sv */
package omp_pkg;

    // Default largest mip0 extent along any axis, in packed bytes.
    localparam int MAX_BASE_DIM_DEF = 64;

    // Field widths of the stream items and the configuration port.
    localparam int KIND_W    = 2;
    localparam int COORD_W   = 6;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 8;
    localparam int M_TUSER_W = 1;

    // Item kinds carried in the input tuser.
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ1 = 2'd2;
    localparam logic [KIND_W-1:0] KIND_READ2 = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_DEPTH  = 2'd2;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;
        logic clear_step;
        logic calc_mul;
        logic calc_idx;
        logic mem_read;
        logic mem_write;
        logic out_load;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic out_busy;
    } t_ctl_sts;

endpackage

/* design/omp_ctrl.sv */
module omp_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    input  logic [omp_pkg::KIND_W-1:0]   i_s_kind,
    output logic                         o_s_tready,
    input  omp_pkg::t_ctl_sts            i_sts,
    output omp_pkg::t_ctl_cmd            o_cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MUL   = 3'd2;
    localparam logic [2:0] ST_IDX   = 3'd3;
    localparam logic [2:0] ST_READ  = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic [omp_pkg::KIND_W-1:0]   r_kind;
    logic [omp_pkg::KIND_W-1:0]   n_kind;

    assign o_s_tready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_kind  = r_kind;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_kind          = i_s_kind;
                    if (i_s_kind == omp_pkg::KIND_CLEAR) begin
                        n_state = ST_CLEAR;
                    end else begin
                        n_state = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                o_cmd.calc_mul = 1'b1;
                n_state        = ST_IDX;
            end
            ST_IDX: begin
                o_cmd.calc_idx = 1'b1;
                n_state        = ST_READ;
            end
            ST_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = ST_DONE;
            end
            ST_DONE: begin
                if (r_kind == omp_pkg::KIND_MARK) begin
                    o_cmd.mem_write = 1'b1;
                    n_state         = ST_IDLE;
                end else if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
    end

endmodule

/* design/omp_dpath.sv */
module omp_dpath #(
    parameter int MAX_BASE_DIM = omp_pkg::MAX_BASE_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [omp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [omp_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic [omp_pkg::S_TDATA_W-1:0]   i_s_tdata,
    input  logic [omp_pkg::KIND_W-1:0]      i_s_tuser,
    input  omp_pkg::t_ctl_cmd               i_cmd,
    output omp_pkg::t_ctl_sts               o_sts,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [omp_pkg::M_TDATA_W-1:0]   o_m_tdata,
    output logic [omp_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    localparam int L1_DIM  = ((MAX_BASE_DIM / 2) > 0) ? (MAX_BASE_DIM / 2) : 1;
    localparam int L2_DIM  = ((L1_DIM / 2) > 0) ? (L1_DIM / 2) : 1;
    localparam int L1_SIZE = L1_DIM * L1_DIM * L1_DIM;
    localparam int L2_SIZE = L2_DIM * L2_DIM * L2_DIM;
    localparam int A1_W    = (L1_SIZE > 1) ? $clog2(L1_SIZE) : 1;
    localparam int A2_W    = (L2_SIZE > 1) ? $clog2(L2_SIZE) : 1;
    localparam int DIM_W   = $clog2(MAX_BASE_DIM + 1);
    localparam int CW      = (DIM_W > omp_pkg::COORD_W) ? DIM_W : omp_pkg::COORD_W;
    localparam int PW      = 2 * CW;
    localparam int IW      = 3 * CW;
    localparam int BW      = omp_pkg::BYTE_W;

    // Extent register to effective extent: zero reads as one, large values saturate.
    function automatic logic [DIM_W-1:0] f_eff(input logic [omp_pkg::CFG_W-1:0] v);
        logic [DIM_W-1:0] res;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (int'(v) > MAX_BASE_DIM) begin
            res = DIM_W'(MAX_BASE_DIM);
        end else begin
            res = DIM_W'(v);
        end
        return res;
    endfunction

    // Halve an extent, never below one.
    function automatic logic [DIM_W-1:0] f_half(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] h;
        h = v >> 1;
        if (h == '0) begin
            h = DIM_W'(1);
        end
        return h;
    endfunction

    logic [omp_pkg::CFG_W-1:0]    r_cfg_w;
    logic [omp_pkg::CFG_W-1:0]    r_cfg_h;
    logic [omp_pkg::CFG_W-1:0]    r_cfg_d;

    logic [omp_pkg::KIND_W-1:0]   r_kind;
    logic [omp_pkg::COORD_W-1:0]  r_x;
    logic [omp_pkg::COORD_W-1:0]  r_y;
    logic [omp_pkg::COORD_W-1:0]  r_z;
    logic [BW-1:0]                r_byte;

    logic [DIM_W-1:0] w0, h0, d0, w1, h1, d1, w2, h2, d2;
    logic [omp_pkg::COORD_W-1:0] a1x, a1y, a1z, a2x, a2y, a2z;
    logic             is_mark, ok0, okc1, okc2, byte_nz;

    logic             r_ok1;
    logic             r_ok2;
    logic [PW-1:0]    r_yw1;
    logic [PW-1:0]    r_yw2;
    logic [PW-1:0]    r_plane1;
    logic [PW-1:0]    r_plane2;
    logic [IW-1:0]    sum1;
    logic [IW-1:0]    sum2;
    logic [A1_W-1:0]  r_idx1;
    logic [A2_W-1:0]  r_idx2;
    logic [BW-1:0]    r_rd1;
    logic [BW-1:0]    r_rd2;
    logic [BW-1:0]    bit1;
    logic [BW-1:0]    bit2;
    logic [A1_W-1:0]  r_clr_cnt;
    logic             clear_last;

    logic [BW-1:0]    r_mem1 [L1_SIZE];
    logic [BW-1:0]    r_mem2 [L2_SIZE];

    logic                          r_out_valid;
    logic [omp_pkg::M_TDATA_W-1:0] r_out_data;
    logic                          r_out_oor;

    // Configuration registers; the port never stalls.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= omp_pkg::CFG_RESET;
            r_cfg_h <= omp_pkg::CFG_RESET;
            r_cfg_d <= omp_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                omp_pkg::CFG_BASE_WIDTH:  r_cfg_w <= i_cfg_data;
                omp_pkg::CFG_BASE_HEIGHT: r_cfg_h <= i_cfg_data;
                omp_pkg::CFG_BASE_DEPTH:  r_cfg_d <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        w0 = f_eff(r_cfg_w);
        h0 = f_eff(r_cfg_h);
        d0 = f_eff(r_cfg_d);
        w1 = f_half(w0);
        h1 = f_half(h0);
        d1 = f_half(d0);
        w2 = f_half(w1);
        h2 = f_half(h1);
        d2 = f_half(d1);
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_kind <= i_s_tuser;
            r_x    <= i_s_tdata[5:0];
            r_y    <= i_s_tdata[11:6];
            r_z    <= i_s_tdata[17:12];
            r_byte <= i_s_tdata[25:18];
        end
    end

    // Coordinates at each level: a mark carries mip0 coordinates, a read
    // carries coordinates of the level it addresses.
    always_comb begin
        is_mark = (r_kind == omp_pkg::KIND_MARK);
        byte_nz = (r_byte != '0);
        a1x = is_mark ? (r_x >> 1) : r_x;
        a1y = is_mark ? (r_y >> 1) : r_y;
        a1z = is_mark ? (r_z >> 1) : r_z;
        a2x = is_mark ? (r_x >> 2) : r_x;
        a2y = is_mark ? (r_y >> 2) : r_y;
        a2z = is_mark ? (r_z >> 2) : r_z;
        ok0 = (CW'(r_x) < CW'(w0)) && (CW'(r_y) < CW'(h0)) && (CW'(r_z) < CW'(d0));
        okc1 = (CW'(a1x) < CW'(w1)) && (CW'(a1y) < CW'(h1)) && (CW'(a1z) < CW'(d1));
        okc2 = (CW'(a2x) < CW'(w2)) && (CW'(a2y) < CW'(h2)) && (CW'(a2z) < CW'(d2));
    end

    // First address step: row offsets, plane sizes and range checks.
    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_mul) begin
            r_ok1    <= is_mark ? (byte_nz && ok0 && okc1) : okc1;
            r_ok2    <= is_mark ? (byte_nz && ok0 && okc1 && okc2) : okc2;
            r_yw1    <= PW'(a1y) * PW'(w1);
            r_yw2    <= PW'(a2y) * PW'(w2);
            r_plane1 <= PW'(w1) * PW'(h1);
            r_plane2 <= PW'(w2) * PW'(h2);
        end
    end

    // Second address step: linear x-fastest index.
    assign sum1 = IW'(a1x) + IW'(r_yw1) + IW'(a1z) * IW'(r_plane1);
    assign sum2 = IW'(a2x) + IW'(r_yw2) + IW'(a2z) * IW'(r_plane2);

    always_ff @(posedge i_clk) begin
        if (i_cmd.calc_idx) begin
            r_idx1 <= sum1[A1_W-1:0];
            r_idx2 <= sum2[A2_W-1:0];
        end
    end

    // Child bits: one coordinate bit of each axis selects one of eight (bit 0 for level one, bit 1 for level two).
    assign bit1 = BW'(1) << {r_z[0], r_y[0], r_x[0]};
    assign bit2 = BW'(1) << {r_z[1], r_y[1], r_x[1]};

    // Clearing pass, one entry of each store per cycle.
    assign clear_last = (r_clr_cnt == A1_W'(L1_SIZE - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr_cnt <= clear_last ? '0 : r_clr_cnt + A1_W'(1);
        end
    end

    // Level one store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step) begin
            r_mem1[r_clr_cnt] <= '0;
        end else if (i_cmd.mem_write && r_ok1) begin
            r_mem1[r_idx1] <= r_rd1 | bit1;
        end
        if (i_cmd.mem_read) begin
            r_rd1 <= r_mem1[r_idx1];
        end
    end

    // Level two store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step && (r_clr_cnt < A1_W'(L2_SIZE))) begin
            r_mem2[r_clr_cnt[A2_W-1:0]] <= '0;
        end else if (i_cmd.mem_write && r_ok2) begin
            r_mem2[r_idx2] <= r_rd2 | bit2;
        end
        if (i_cmd.mem_read) begin
            r_rd2 <= r_mem2[r_idx2];
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            if (r_kind == omp_pkg::KIND_READ1) begin
                r_out_data <= r_ok1 ? r_rd1 : '0;
                r_out_oor  <= !r_ok1;
            end else begin
                r_out_data <= r_ok2 ? r_rd2 : '0;
                r_out_oor  <= !r_ok2;
            end
        end
    end

    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = r_out_data;
    assign o_m_tuser        = r_out_oor;
    assign o_sts.clear_last = clear_last;
    assign o_sts.out_busy   = r_out_valid;

endmodule

/* design/occupancy_mip_pyramid.sv */
// Occupancy mip pyramid: keeps two coarse occupancy levels over a 3D grid
// of mip0 occupancy bytes. Each level-one byte covers a 2x2x2 group of mip0
// bytes with one bit per byte, and each level-two byte covers a 2x2x2 group
// of level-one bytes in the same way.
// Input stream: tuser carries the kind (clear, mark, read level one, read
// level two), tdata the coordinates and the mip0 byte. Only reads return a
// transaction on the output stream: tdata is the stored byte, tuser flags
// coordinates outside the addressed level (data then reads zero).
// Every mark or read passes through the address multiply, index sum, store
// read and a final write-back (mark) or output load (read) step before the
// next item is taken; a read waits in its last step while a result is held.
// A clear item sweeps the level-one store one entry per cycle, clearing
// level two in the same pass; the sweep covers MAX_BASE_DIM/2 cubed entries
// (32768 at the default).
// After reset the same clearing pass runs before the first item is taken;
// configuration writes are accepted at any time and never stall.
// A stalled receiver holds the result in the output register; the block
// still takes the next item and only stops before delivering a new result.
module occupancy_mip_pyramid #(
    parameter int MAX_BASE_DIM = omp_pkg::MAX_BASE_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [omp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [omp_pkg::CFG_W-1:0]       i_cfg_data,
    // Input stream.
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // Fields from bit 0: coord_x[5:0], coord_y[11:6], coord_z[17:12],
    // base_byte[25:18], zero fill [31:26].
    input  logic [omp_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // Fields from bit 0: kind[1:0].
    input  logic [omp_pkg::KIND_W-1:0]      i_s_tuser,
    // Output stream.
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // Fields from bit 0: read_data[7:0].
    output logic [omp_pkg::M_TDATA_W-1:0]   o_m_tdata,
    // Fields from bit 0: out_of_range[0].
    output logic [omp_pkg::M_TUSER_W-1:0]   o_m_tuser
);

    omp_pkg::t_ctl_cmd cmd;
    omp_pkg::t_ctl_sts sts;

    // The controller sequences each item; the datapath holds the stores,
    // the configuration and the output register.
    omp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_kind   (i_s_tuser),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    omp_dpath #(
        .MAX_BASE_DIM (MAX_BASE_DIM)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

endmodule

/* verif/occupancy_mip_pyramid_tb.sv */
module occupancy_mip_pyramid_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Clock and run-length constants.
    localparam int CLK_PERIOD = 10;
    // A short pause after the last result guarantees that any trailing mark
    // has been written back.
    localparam int IDLE_PAUSE = 8;
    localparam int DRAIN_CYCLES = 20;
    // A clear sweeps MAX_BASE_DIM/2 cubed entries (32768 at the default), and
    // the same sweep runs after reset. The watchdog allows several of those.
    localparam int STALL_LIMIT = 150000;
    // Long receiver hold-off used to back the block up into its input.
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int NUM_PHASES = 10;
    localparam int PHASE_ITEMS = 160;
    localparam int PLAN_ROWS = 30;
    localparam int RECENT_DEPTH = 16;

    // Geometry of the two coarse levels at the block's default size.
    localparam int MAX_DIM = omp_pkg::MAX_BASE_DIM_DEF;
    localparam int L1_DIM = (MAX_DIM / 2 > 0) ? MAX_DIM / 2 : 1;
    localparam int L2_DIM = (L1_DIM / 2 > 0) ? L1_DIM / 2 : 1;
    localparam int L1_CELLS = L1_DIM * L1_DIM * L1_DIM;
    localparam int L2_CELLS = L2_DIM * L2_DIM * L2_DIM;

    // Register index that maps to nothing; writes to it must be dropped.
    localparam logic [omp_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef logic [omp_pkg::KIND_W-1:0]  t_kind;
    typedef logic [omp_pkg::COORD_W-1:0] t_coord;
    typedef logic [omp_pkg::BYTE_W-1:0]  t_occ;
    typedef logic [omp_pkg::CFG_W-1:0]   t_cfg;

    // One returned read transaction.
    typedef struct packed {
        logic [omp_pkg::BYTE_W-1:0] data;
        logic                       oor;
    } t_read_result;

    // What a row of the directed plan does: send an item checked by the
    // predictor, send a read whose result is typed into the row, or write a
    // configuration register.
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_TYPED,
        ROW_REG
    } t_row_act;

    typedef struct packed {
        t_row_act                      act;
        logic [omp_pkg::KIND_W-1:0]    kind;
        logic [omp_pkg::COORD_W-1:0]   x;
        logic [omp_pkg::COORD_W-1:0]   y;
        logic [omp_pkg::COORD_W-1:0]   z;
        logic [omp_pkg::BYTE_W-1:0]    occ;
        logic [omp_pkg::BYTE_W-1:0]    exp_data;
        logic                          exp_oor;
        logic [omp_pkg::CFG_IDX_W-1:0] reg_idx;
        logic [omp_pkg::CFG_W-1:0]     reg_val;
    } t_plan_row;

    // DUT ports. Every input starts at a known value.
    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [omp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [omp_pkg::CFG_W-1:0]     i_cfg_data = '0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [omp_pkg::S_TDATA_W-1:0] i_s_tdata = '0;
    logic [omp_pkg::KIND_W-1:0]    i_s_tuser = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [omp_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [omp_pkg::M_TUSER_W-1:0] o_m_tuser;

    // Predictor state: its own copy of the extent registers and both stores.
    logic [omp_pkg::CFG_W-1:0] ext_width = omp_pkg::CFG_RESET;
    logic [omp_pkg::CFG_W-1:0] ext_height = omp_pkg::CFG_RESET;
    logic [omp_pkg::CFG_W-1:0] ext_depth = omp_pkg::CFG_RESET;
    logic [omp_pkg::BYTE_W-1:0] level_one_bits [L1_CELLS];
    logic [omp_pkg::BYTE_W-1:0] level_two_bits [L2_CELLS];

    // Read results still owed by the block, oldest first.
    t_read_result reads_owed [$];
    // mip0 coordinates {z, y, x} of recent marks that took effect; reads aim
    // at their parents so that most reads return populated cells.
    logic [3*omp_pkg::COORD_W-1:0] marked_spots [$];

    int  mismatches = 0;
    int  quiet_cycles = 0;
    int  burst_left = 0;
    bit  hold_off_req = 1'b0;

    // Extents of the random phases. The last two phases draw their own.
    logic [omp_pkg::CFG_W-1:0] phase_w [NUM_PHASES] =
        '{7'd64, 7'd1, 7'd0, 7'd5, 7'd2, 7'd127, 7'd9, 7'd65, 7'd0, 7'd0};
    logic [omp_pkg::CFG_W-1:0] phase_h [NUM_PHASES] =
        '{7'd64, 7'd1, 7'd127, 7'd6, 7'd3, 7'd0, 7'd64, 7'd11, 7'd0, 7'd0};
    logic [omp_pkg::CFG_W-1:0] phase_d [NUM_PHASES] =
        '{7'd64, 7'd1, 7'd65, 7'd7, 7'd4, 7'd2, 7'd3, 7'd13, 7'd0, 7'd0};

    // Directed plan. It starts at the reset extents of 64 on every axis and
    // covers reads at both level corners, reads just past each level, marks
    // with the widest and a zero byte, the far corner, a clear, then a zero
    // width, a height past the maximum, odd depths and heights that drop a
    // mark or leave level two untouched, and a write to an unused index.
    t_plan_row plan_rows [PLAN_ROWS] = '{
        '{ROW_TYPED, omp_pkg::KIND_READ1,  0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ2, 15, 15, 15, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1, 32,  0,  0, 8'h00, 8'h00, 1'b1, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ2,  0,  0, 16, 8'h00, 8'h00, 1'b1, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   1,  1,  1, 8'hff, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1,  0,  0,  0, 8'h00, 8'h80, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ2,  0,  0,  0, 8'h00, 8'h01, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1,  0,  0,  0, 8'h00, 8'h80, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,  63, 63, 63, 8'h01, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1, 31, 31, 31, 8'h00, 8'h80, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ2, 15, 15, 15, 8'h00, 8'h80, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1, 63, 63, 63, 8'h00, 8'h00, 1'b1, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ1, 31, 31, 31, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_TYPED, omp_pkg::KIND_READ2,  0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_REG,   omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0,
          omp_pkg::CFG_BASE_WIDTH, 7'd0},
        '{ROW_REG,   omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0,
          omp_pkg::CFG_BASE_HEIGHT, 7'd127},
        '{ROW_REG,   omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0,
          omp_pkg::CFG_BASE_DEPTH, 7'd3},
        '{ROW_REG,   omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0,
          CFG_UNUSED_IDX, 7'd5},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   0,  2,  1, 8'h80, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_READ1,  0,  1,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_READ2,  0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   0,  0,  2, 8'h55, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   1,  0,  0, 8'h3c, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_READ1,  0,  0,  1, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_REG,   omp_pkg::KIND_CLEAR,  0,  0,  0, 8'h00, 8'h00, 1'b0,
          omp_pkg::CFG_BASE_HEIGHT, 7'd6},
        '{ROW_ITEM,  omp_pkg::KIND_MARK,   0,  5,  0, 8'h01, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_READ1,  0,  2,  0, 8'h00, 8'h00, 1'b0, 0, 0},
        '{ROW_ITEM,  omp_pkg::KIND_READ2,  0,  0,  0, 8'h00, 8'h00, 1'b0, 0, 0}
    };

    occupancy_mip_pyramid dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // An extent register of zero means one byte; anything above the maximum
    // saturates.
    function automatic int unsigned axis_extent(input logic [omp_pkg::CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return v;
    endfunction

    // Each level halves the one below, never dropping under one cell.
    function automatic int unsigned halve_dim(input int unsigned v);
        return ((v >> 1) == 0) ? 1 : (v >> 1);
    endfunction

    function automatic void clear_levels();
        foreach (level_one_bits[i]) level_one_bits[i] = '0;
        foreach (level_two_bits[i]) level_two_bits[i] = '0;
    endfunction

    function automatic void set_extent(input logic [omp_pkg::CFG_IDX_W-1:0] idx,
                                       input logic [omp_pkg::CFG_W-1:0] val);
        case (idx)
            omp_pkg::CFG_BASE_WIDTH: ext_width = val;
            omp_pkg::CFG_BASE_HEIGHT: ext_height = val;
            omp_pkg::CFG_BASE_DEPTH: ext_depth = val;
            default: ;
        endcase
    endfunction

    // Applies one accepted item to the predicted stores. Returns 1 when the
    // item owes a read result, which is then in res. took is 0 for items the
    // block merely ignores (marks with a zero byte or outside the grid).
    function automatic bit pyramid_step(input logic [omp_pkg::KIND_W-1:0] kind,
                                        input logic [omp_pkg::COORD_W-1:0] x, y, z,
                                        input logic [omp_pkg::BYTE_W-1:0] occ,
                                        output t_read_result res, output bit took);
        int unsigned w0, h0, d0, w1, h1, d1, w2, h2, d2;
        int unsigned x1, y1, z1, lw, lh, ld, slot_idx;
        w0 = axis_extent(ext_width);
        h0 = axis_extent(ext_height);
        d0 = axis_extent(ext_depth);
        w1 = halve_dim(w0);
        h1 = halve_dim(h0);
        d1 = halve_dim(d0);
        w2 = halve_dim(w1);
        h2 = halve_dim(h1);
        d2 = halve_dim(d1);
        res = '0;
        took = 1'b1;
        case (kind)
            omp_pkg::KIND_CLEAR: begin
                clear_levels();
                return 1'b0;
            end
            omp_pkg::KIND_MARK: begin
                x1 = x >> 1;
                y1 = y >> 1;
                z1 = z >> 1;
                // A zero byte, a spot outside mip0, or a level-one cell cut
                // off by an odd extent all leave the stores alone.
                if (occ == 0 || x >= w0 || y >= h0 || z >= d0 ||
                        x1 >= w1 || y1 >= h1 || z1 >= d1) begin
                    took = 1'b0;
                    return 1'b0;
                end
                slot_idx = x1 + y1 * w1 + z1 * w1 * h1;
                if (slot_idx < L1_CELLS)
                    level_one_bits[slot_idx][{z[0], y[0], x[0]}] = 1'b1;
                // The level-two parent may fall outside level two when the
                // level-one extent is odd; level one is still updated.
                if ((x1 >> 1) < w2 && (y1 >> 1) < h2 && (z1 >> 1) < d2) begin
                    slot_idx = (x1 >> 1) + (y1 >> 1) * w2 + (z1 >> 1) * w2 * h2;
                    if (slot_idx < L2_CELLS)
                        level_two_bits[slot_idx][{z1[0], y1[0], x1[0]}] = 1'b1;
                end
                return 1'b0;
            end
            default: begin
                lw = (kind == omp_pkg::KIND_READ1) ? w1 : w2;
                lh = (kind == omp_pkg::KIND_READ1) ? h1 : h2;
                ld = (kind == omp_pkg::KIND_READ1) ? d1 : d2;
                if (x < lw && y < lh && z < ld) begin
                    slot_idx = x + y * lw + z * lw * lh;
                    if (kind == omp_pkg::KIND_READ1) begin
                        if (slot_idx < L1_CELLS) res.data = level_one_bits[slot_idx];
                    end else if (slot_idx < L2_CELLS) begin
                        res.data = level_two_bits[slot_idx];
                    end
                end else begin
                    res.oor = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Offers one item on the input stream and returns once the transaction
    // is taken, with the predicted outcome. Items go out in bursts of random
    // length; between bursts the valid drops for a random gap, which may be
    // zero so that long runs with no idling occur too.
    task automatic send_item(input logic [omp_pkg::KIND_W-1:0] kind,
                             input logic [omp_pkg::COORD_W-1:0] x, y, z,
                             input logic [omp_pkg::BYTE_W-1:0] occ,
                             output t_read_result res, output bit has_res, output bit took);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(0, 2);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {{(omp_pkg::S_TDATA_W - 3 * omp_pkg::COORD_W - omp_pkg::BYTE_W){1'b0}},
                      occ, z, y, x};
        i_s_tuser <= kind;
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        has_res = pyramid_step(kind, x, y, z, occ, res, took);
    endtask

    // Register writes happen only with the block idle: the input is quiet,
    // every owed result has come back, any trailing mark has had time to
    // finish its write-back, and a trailing clearing sweep has run to its end.
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (reads_owed.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
        while (o_s_tready !== 1'b1) @(posedge i_clk);
    endtask

    // The valid stays high across back-to-back writes; the caller lowers it
    // after the last write of a group.
    task automatic write_reg(input logic [omp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [omp_pkg::CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        set_extent(idx, val);
    endtask

    initial begin : stimulus
        t_plan_row                     row;
        t_read_result                  res;
        bit                            has_res, took;
        logic [omp_pkg::KIND_W-1:0]    kind;
        logic [omp_pkg::COORD_W-1:0]   cx, cy, cz;
        logic [omp_pkg::BYTE_W-1:0]    occ;
        logic [3*omp_pkg::COORD_W-1:0] spot;
        logic [omp_pkg::CFG_W-1:0]     pw, ph, pd;
        int unsigned                   w0, h0, d0, lw, lh, ld, shift;
        int                            pick, counted;

        clear_levels();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed plan. The block runs its clearing sweep first, so the
        // first item simply waits for the input to open.
        for (int i = 0; i < PLAN_ROWS; i++) begin
            row = plan_rows[i];
            if (row.act == ROW_REG) begin
                if (i == 0 || plan_rows[i - 1].act != ROW_REG) wait_idle();
                write_reg(row.reg_idx, row.reg_val);
                if (i + 1 == PLAN_ROWS || plan_rows[i + 1].act != ROW_REG)
                    i_cfg_valid <= 1'b0;
            end else begin
                send_item(row.kind, row.x, row.y, row.z, row.occ, res, has_res, took);
                if (has_res) begin
                    if (row.act == ROW_TYPED)
                        reads_owed.push_back('{data: row.exp_data, oor: row.exp_oor});
                    else
                        reads_owed.push_back(res);
                end
            end
        end

        // Random phases, each under its own extents. Most items are marks and
        // reads inside the grid, with reads aimed at parents of recent marks;
        // a few are full-range noise and a rare one is a clear.
        for (int p = 0; p < NUM_PHASES; p++) begin
            pw = phase_w[p];
            ph = phase_h[p];
            pd = phase_d[p];
            if (p >= NUM_PHASES - 2) begin
                pw = t_cfg'($urandom_range(0, 127));
                ph = t_cfg'($urandom_range(0, 127));
                pd = t_cfg'($urandom_range(0, 127));
            end
            wait_idle();
            write_reg(omp_pkg::CFG_BASE_WIDTH, pw);
            write_reg(omp_pkg::CFG_BASE_HEIGHT, ph);
            write_reg(omp_pkg::CFG_BASE_DEPTH, pd);
            write_reg(CFG_UNUSED_IDX, t_cfg'($urandom_range(0, 127)));
            i_cfg_valid <= 1'b0;
            marked_spots.delete();
            // Twice in the run the receiver stops for a long stretch while
            // items keep coming, so the block backs up into its input.
            if (p == 2 || p == 6) hold_off_req = 1'b1;

            w0 = axis_extent(ext_width);
            h0 = axis_extent(ext_height);
            d0 = axis_extent(ext_depth);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 255);
                occ = '0;
                cx = t_coord'($urandom_range(0, 63));
                cy = t_coord'($urandom_range(0, 63));
                cz = t_coord'($urandom_range(0, 63));
                if (pick == 0) begin
                    kind = omp_pkg::KIND_CLEAR;
                end else if (pick < 16) begin
                    kind = t_kind'($urandom_range(1, 3));
                    occ = t_occ'($urandom_range(0, 255));
                end else if (pick < 128) begin
                    kind = omp_pkg::KIND_MARK;
                    occ = ($urandom_range(0, 4) == 0) ? 8'h00 : t_occ'($urandom_range(1, 255));
                    if ($urandom_range(0, 7) != 0) begin
                        cx = t_coord'($urandom_range(0, w0 - 1));
                        cy = t_coord'($urandom_range(0, h0 - 1));
                        cz = t_coord'($urandom_range(0, d0 - 1));
                    end
                end else begin
                    kind = ($urandom_range(0, 1) == 0) ? omp_pkg::KIND_READ1
                                                       : omp_pkg::KIND_READ2;
                    shift = (kind == omp_pkg::KIND_READ1) ? 1 : 2;
                    lw = halve_dim(w0);
                    lh = halve_dim(h0);
                    ld = halve_dim(d0);
                    if (kind == omp_pkg::KIND_READ2) begin
                        lw = halve_dim(lw);
                        lh = halve_dim(lh);
                        ld = halve_dim(ld);
                    end
                    pick = $urandom_range(0, 9);
                    if (pick < 6 && marked_spots.size() != 0) begin
                        spot = marked_spots[$urandom_range(0, marked_spots.size() - 1)];
                        cx = spot[omp_pkg::COORD_W-1:0] >> shift;
                        cy = spot[2*omp_pkg::COORD_W-1:omp_pkg::COORD_W] >> shift;
                        cz = spot[3*omp_pkg::COORD_W-1:2*omp_pkg::COORD_W] >> shift;
                    end else if (pick < 9) begin
                        cx = t_coord'($urandom_range(0, lw - 1));
                        cy = t_coord'($urandom_range(0, lh - 1));
                        cz = t_coord'($urandom_range(0, ld - 1));
                    end
                end
                send_item(kind, cx, cy, cz, occ, res, has_res, took);
                if (has_res) reads_owed.push_back(res);
                if (took) begin
                    counted++;
                    if (kind == omp_pkg::KIND_MARK) begin
                        marked_spots.push_back({cz, cy, cx});
                        if (marked_spots.size() > RECENT_DEPTH) void'(marked_spots.pop_front());
                    end
                end
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && reads_owed.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Receiver. It cycles through modes of random length: always ready,
    // randomly ready, and a fixed duty pattern. A hold-off request from the
    // stimulus turns into one long stall counted here.
    initial begin : result_sink
        int mode, mode_left, hold_left, tick;
        mode = 0;
        mode_left = 0;
        tick = 0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (hold_off_req) begin
                i_m_tready <= 1'b0;
                for (hold_left = HOLD_OFF_CYCLES; hold_left > 0; hold_left--)
                    @(posedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    0: i_m_tready <= 1'b1;
                    1: i_m_tready <= ($urandom_range(0, 3) != 0);
                    default: i_m_tready <= ((tick % 7) < 4);
                endcase
            end
        end
    end

    // Each output transaction is compared field by field with the oldest
    // owed read.
    always @(posedge i_clk) begin : read_check
        t_read_result want;
        if (i_rst_n && o_m_tvalid === 1'b1 && i_m_tready) begin
            if (reads_owed.size() == 0) begin
                $error("unexpected read transaction: read_data=%0h out_of_range=%0b",
                       o_m_tdata, o_m_tuser[0]);
                mismatches++;
            end else begin
                want = reads_owed.pop_front();
                if (o_m_tdata !== want.data) begin
                    $error("read_data: expected %0h, got %0h", want.data, o_m_tdata);
                    mismatches++;
                end
                if (o_m_tuser[0] !== want.oor) begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, o_m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind has moved for
    // too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready === 1'b1) ||
                (o_m_tvalid === 1'b1 && i_m_tready) ||
                (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

endmodule
